// File: sv/flash_download_protocol_engine_defines.svh
// ============================================================================
// Flash download protocol engine assertion macros
// Concurrent check macros, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef FLASH_DOWNLOAD_PROTOCOL_ENGINE_DEFINES_SVH
`define FLASH_DOWNLOAD_PROTOCOL_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FDPE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define FDPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define FDPE_ASSERT_SAME(lbl, ante, cons)
`define FDPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/fdpe_pkg.sv
// ============================================================================
// Flash download protocol engine package
// Shared types, protocol codes and the CRC-32 byte update.
// ============================================================================
package fdpe_pkg;

    localparam int unsigned DEF_CHUNK_BYTES = 1024;
    localparam int unsigned MAX_RESULTS     = 6;

    localparam logic [7:0] CMD_SESSION  = 8'h10;
    localparam logic [7:0] CMD_DOWNLOAD = 8'h34;
    localparam logic [7:0] CMD_TRANSFER = 8'h36;
    localparam logic [7:0] CMD_CRC      = 8'h31;
    localparam logic [7:0] CMD_EXIT     = 8'h37;
    localparam logic [7:0] RESP_OFFSET  = 8'h10;
    localparam logic [7:0] NEG_RESP     = 8'h7F;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

    localparam logic REG_UPDATE_MARK  = 1'b0;
    localparam logic REG_MARK_ADDRESS = 1'b1;

    localparam logic [1:0] MARK_BLANK  = 2'd0;
    localparam logic [1:0] MARK_UPDATE = 2'd1;

    localparam logic [2:0] SECTOR_MARK = 3'd1;

    typedef enum logic [2:0] {
        PH_SESSION  = 3'd0,
        PH_DOWNLOAD = 3'd1,
        PH_TRANSFER = 3'd2,
        PH_CRC      = 3'd3,
        PH_EXIT     = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_ERASE   = 2'd1,
        KIND_PROGRAM = 2'd2,
        KIND_RESET   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [2:0]  sector;
        logic [31:0] address;
        logic [31:0] data;
    } result_t;

    typedef struct packed {
        logic [2:0]                   count;
        result_t [MAX_RESULTS-1:0]    res;
    } job_t;

    // Advance the reflected CRC-32 by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic result_t mk_send(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind    = KIND_SEND;
        r.tx_byte = b;
        return r;
    endfunction

    function automatic result_t mk_erase(input logic [2:0] s);
        result_t r;
        r = '0;
        r.kind   = KIND_ERASE;
        r.sector = s;
        return r;
    endfunction

    function automatic result_t mk_prog(input logic [31:0] a, input logic [31:0] d);
        result_t r;
        r = '0;
        r.kind    = KIND_PROGRAM;
        r.address = a;
        r.data    = d;
        return r;
    endfunction

    function automatic result_t mk_reset();
        result_t r;
        r = '0;
        r.kind = KIND_RESET;
        return r;
    endfunction

endpackage

// File: sv/fdpe_core.sv
// ============================================================================
// Flash download protocol engine core
// Holds the protocol state and builds the result list of one request.
// ============================================================================
module fdpe_core
    import fdpe_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic [1:0]  update_mark,
    input  logic [31:0] mark_address,
    output job_t        job
);

    localparam int unsigned CW  = $clog2(CHUNK_BYTES + 1);
    localparam int unsigned BCW = (CW > 4) ? CW : 4;
    localparam logic [31:0] CHUNK = 32'(CHUNK_BYTES);

    phase_t         phase_reg, phase_next;
    logic           step_reg, step_next;
    logic [BCW-1:0] bc_reg, bc_next, bc_inc;
    logic [31:0]    entry_reg, entry_next;
    logic [31:0]    size_reg, size_next;
    logic [31:0]    first_reg, first_next;
    logic [31:0]    remain_reg, remain_next;
    logic [31:0]    waddr_reg, waddr_next;
    logic [31:0]    word_reg, word_next;
    logic [31:0]    crc_reg, crc_next;
    logic [31:0]    chunk_len;
    logic [2:0]     n;

    assign bc_inc    = bc_reg + 1'b1;
    assign chunk_len = (remain_reg != 32'd0 && remain_reg <= CHUNK) ? remain_reg : CHUNK;

    // Work out next state and results of the request
    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        bc_next     = bc_reg;
        entry_next  = entry_reg;
        size_next   = size_reg;
        first_next  = first_reg;
        remain_next = remain_reg;
        waddr_next  = waddr_reg;
        word_next   = word_reg;
        crc_next    = crc_reg;
        job         = '0;
        n           = 3'd0;
        if (action)
        begin
            if (phase_reg == PH_SESSION && update_mark == MARK_UPDATE)
            begin
                job.res[n] = mk_send(CMD_SESSION + RESP_OFFSET); n = n + 3'd1;
                job.res[n] = mk_erase(SECTOR_MARK);              n = n + 3'd1;
                phase_next = PH_DOWNLOAD;
                step_next  = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SESSION:
                begin
                    if (update_mark == MARK_BLANK)
                    begin
                        if (rx_byte == CMD_SESSION)
                        begin
                            job.res[n] = mk_send(CMD_SESSION + RESP_OFFSET); n = n + 3'd1;
                            phase_next = PH_DOWNLOAD;
                            step_next  = 1'b0;
                        end
                        else
                        begin
                            job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                        end
                    end
                end
                PH_DOWNLOAD:
                begin
                    if (!step_reg)
                    begin
                        if (rx_byte == CMD_DOWNLOAD)
                        begin
                            step_next = 1'b1;
                            bc_next   = '0;
                        end
                        else
                        begin
                            job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                            phase_next = PH_SESSION;
                            step_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        // Shift header bytes into big-endian words
                        if (bc_reg[3:2] == 2'd0)
                            entry_next = {entry_reg[23:0], rx_byte};
                        else if (bc_reg[3:2] == 2'd1)
                            size_next = {size_reg[23:0], rx_byte};
                        else
                            first_next = {first_reg[23:0], rx_byte};
                        bc_next = bc_inc;
                        if (bc_inc >= BCW'(12))
                        begin
                            job.res[n] = mk_send(CMD_DOWNLOAD + RESP_OFFSET); n = n + 3'd1;
                            job.res[n] = mk_erase(3'd2); n = n + 3'd1;
                            job.res[n] = mk_erase(3'd3); n = n + 3'd1;
                            job.res[n] = mk_erase(3'd4); n = n + 3'd1;
                            job.res[n] = mk_erase(3'd5); n = n + 3'd1;
                            remain_next = size_next;
                            waddr_next  = first_next;
                            crc_next    = CRC_INIT;
                            word_next   = '0;
                            bc_next     = '0;
                            phase_next  = PH_TRANSFER;
                            step_next   = 1'b0;
                        end
                    end
                end
                PH_TRANSFER:
                begin
                    if (!step_reg)
                    begin
                        if (rx_byte == CMD_TRANSFER)
                        begin
                            if (remain_reg == 32'd0)
                            begin
                                job.res[n] = mk_send(CMD_TRANSFER + RESP_OFFSET); n = n + 3'd1;
                                phase_next = PH_CRC;
                            end
                            else
                            begin
                                step_next = 1'b1;
                                bc_next   = '0;
                                word_next = '0;
                            end
                        end
                        else
                        begin
                            job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                            phase_next = PH_SESSION;
                            step_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        // Pack data little-endian and fold into the CRC
                        crc_next  = crc_byte(crc_reg, rx_byte);
                        word_next = word_reg | ({24'd0, rx_byte} << {bc_reg[1:0], 3'b000});
                        bc_next   = bc_inc;
                        if (bc_inc[1:0] == 2'd0 || 32'(bc_inc) >= chunk_len)
                        begin
                            job.res[n] = mk_prog(waddr_reg, word_next); n = n + 3'd1;
                            waddr_next = waddr_reg + 32'd4;
                            word_next  = '0;
                        end
                        if (32'(bc_inc) >= chunk_len)
                        begin
                            job.res[n] = mk_send(CMD_TRANSFER + RESP_OFFSET); n = n + 3'd1;
                            bc_next   = '0;
                            step_next = 1'b0;
                            if (remain_reg <= CHUNK)
                                phase_next = PH_CRC;
                            else
                                remain_next = remain_reg - CHUNK;
                        end
                    end
                end
                PH_CRC:
                begin
                    if (!step_reg)
                    begin
                        if (rx_byte == CMD_CRC)
                        begin
                            step_next = 1'b1;
                            bc_next   = '0;
                            word_next = '0;
                        end
                        else
                        begin
                            job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                            phase_next = PH_SESSION;
                            step_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        // Collect the big-endian check word and compare
                        word_next = {word_reg[23:0], rx_byte};
                        bc_next   = bc_inc;
                        if (bc_inc >= BCW'(4))
                        begin
                            bc_next   = '0;
                            step_next = 1'b0;
                            if (word_next == ~crc_reg)
                            begin
                                job.res[n] = mk_send(CMD_CRC + RESP_OFFSET); n = n + 3'd1;
                                phase_next = PH_EXIT;
                            end
                            else
                            begin
                                job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                            end
                            word_next = '0;
                        end
                    end
                end
                PH_EXIT:
                begin
                    if (rx_byte == CMD_EXIT)
                    begin
                        job.res[n] = mk_send(CMD_EXIT + RESP_OFFSET); n = n + 3'd1;
                        job.res[n] = mk_erase(SECTOR_MARK); n = n + 3'd1;
                        job.res[n] = mk_prog(mark_address, first_reg); n = n + 3'd1;
                        job.res[n] = mk_prog(mark_address + 32'd4, entry_reg); n = n + 3'd1;
                        job.res[n] = mk_prog(mark_address + 32'd8, size_reg); n = n + 3'd1;
                        job.res[n] = mk_reset(); n = n + 3'd1;
                        phase_next = PH_DONE;
                        step_next  = 1'b0;
                    end
                    else
                    begin
                        job.res[n] = mk_send(NEG_RESP); n = n + 3'd1;
                        phase_next = PH_SESSION;
                        step_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            // Return to session re-enters download when an update is requested
            if (phase_next == PH_SESSION && phase_reg != PH_SESSION
                && update_mark == MARK_UPDATE)
            begin
                job.res[n] = mk_send(CMD_SESSION + RESP_OFFSET); n = n + 3'd1;
                job.res[n] = mk_erase(SECTOR_MARK); n = n + 3'd1;
                phase_next = PH_DOWNLOAD;
            end
            else if (phase_reg == PH_SESSION && update_mark == MARK_UPDATE)
            begin
                // session with mark set ignores bytes
            end
        end
        job.count = n;
    end

    // Hold protocol state, advance on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SESSION;
            step_reg   <= 1'b0;
            bc_reg     <= '0;
            entry_reg  <= '0;
            size_reg   <= '0;
            first_reg  <= '0;
            remain_reg <= '0;
            waddr_reg  <= '0;
            word_reg   <= '0;
            crc_reg    <= CRC_INIT;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            bc_reg     <= bc_next;
            entry_reg  <= entry_next;
            size_reg   <= size_next;
            first_reg  <= first_next;
            remain_reg <= remain_next;
            waddr_reg  <= waddr_next;
            word_reg   <= word_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

// File: sv/flash_download_protocol_engine.sv
// ============================================================================
// Flash download protocol engine
// Serial download protocol: answers commands, erases sectors, programs words, requests reset.
// ============================================================================
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_stall   | action, rx_byte
//  out     | out       | out_valid / out_stall | kind, tx_byte, sector, address, data, last
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
//  A request is decoded in the cycle it is accepted; its results (up to six)
//  leave one per cycle from the result register while out_stall is low. A new
//  request is taken in the cycle the last result leaves. Requests without
//  results go through at one per cycle.
//  Reset is asynchronous and returns the engine to the session phase.
// ============================================================================
`include "flash_download_protocol_engine_defines.svh"

module flash_download_protocol_engine
    import fdpe_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [2:0]  sector,
    output logic [31:0] address,
    output logic [31:0] data,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [1:0]  mark_reg;
    logic [31:0] maddr_reg;
    job_t        job_new;
    job_t        job_reg;
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic        take;
    logic        final_take;
    logic        acc;
    result_t     cur;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= '0;
            maddr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPDATE_MARK:  mark_reg  <= cfg_data[1:0];
                REG_MARK_ADDRESS: maddr_reg <= cfg_data;
                default:          mark_reg  <= mark_reg;
            endcase
        end
    end

    assign take       = busy_reg && !out_stall;
    assign final_take = take && (idx_reg == job_reg.count - 3'd1);
    assign in_stall   = busy_reg && !final_take;
    assign acc        = in_valid && !in_stall;

    fdpe_core #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (acc),
        .action       (action),
        .rx_byte      (rx_byte),
        .update_mark  (mark_reg),
        .mark_address (maddr_reg),
        .job          (job_new)
    );

    // Load the result list, advance through it one result per cycle while out_stall is low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (acc && job_new.count != 3'd0)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (final_take)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && job_new.count != 3'd0)
            job_reg <= job_new;
    end

    assign cur       = job_reg.res[idx_reg];
    assign out_valid = busy_reg;
    assign kind      = cur.kind;
    assign tx_byte   = cur.tx_byte;
    assign sector    = cur.sector;
    assign address   = cur.address;
    assign data      = cur.data;
    assign last      = (idx_reg == job_reg.count - 3'd1);

    `FDPE_ASSERT_SAME(a_idx_in_list, busy_reg, idx_reg < job_reg.count)
    `FDPE_ASSERT_SAME(a_stall_only_busy, in_stall, out_valid)
    `FDPE_ASSERT_NEXT(a_load_starts, acc && job_new.count != 3'd0, busy_reg && idx_reg == 3'd0)
    `FDPE_ASSERT_NEXT(a_step_on, take && !final_take, busy_reg && idx_reg == $past(idx_reg) + 3'd1)

endmodule

// File: dv/tb_flash_download_protocol_engine.sv
// ============================================================================
// Flash download protocol engine testbench
// Drives serial bytes and start events through whole download sessions,
// predicts every send, erase, program and reset result, and compares them
// field by field with the engine output under random idling on both sides.
// ============================================================================
module tb_flash_download_protocol_engine;
    import fdpe_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [2:0]  sector;
        logic [31:0] address;
        logic [31:0] data;
        logic        last;
    } outcome_t;

    typedef struct {
        logic       action;
        logic [7:0] rx_byte;
        int         n_known;
        logic [7:0] first_tx;
    } row_t;

    localparam int CHUNK = 1024;
    localparam int LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [2:0]  sector;
    logic [31:0] address;
    logic [31:0] data;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Predictor state
    logic [1:0]  mark_cfg;
    logic [31:0] mark_addr_cfg;
    phase_t      ph;
    logic [1:0]  stp;
    logic [10:0] cnt;
    logic [31:0] entry_w;
    logic [31:0] size_w;
    logic [31:0] first_w;
    logic [31:0] left_w;
    logic [31:0] wr_addr;
    logic [31:0] packed_w;
    logic [31:0] crc_acc;

    outcome_t pending_results[$];
    outcome_t step_results[$];
    int  errors;
    int  cycles;
    int  n_results;
    int  n_sessions;
    bit  idle_on;

    flash_download_protocol_engine DUT (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t", $time);
            $display("FAIL flash_download_protocol_engine");
            $finish;
        end
    end

    function automatic outcome_t mk(logic [1:0] k, logic [7:0] t, logic [2:0] s,
                                    logic [31:0] a, logic [31:0] d);
        outcome_t o;
        o = '{kind: k, tx_byte: t, sector: s, address: a, data: d, last: 1'b0};
        return o;
    endfunction

    function automatic logic [31:0] crc_advance(logic [31:0] c0, logic [7:0] b);
        logic [31:0] c;
        c = c0 ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    task automatic enter_download_phase();
        step_results.push_back(mk(KIND_SEND, CMD_SESSION + RESP_OFFSET, 0, 0, 0));
        step_results.push_back(mk(KIND_ERASE, 0, SECTOR_MARK, 0, 0));
        ph = PH_DOWNLOAD;
        stp = 0;
    endtask

    task automatic reject_to_session();
        step_results.push_back(mk(KIND_SEND, NEG_RESP, 0, 0, 0));
        ph = PH_SESSION;
        stp = 0;
        if (mark_cfg == MARK_UPDATE)
            enter_download_phase();
    endtask

    // Work out the results of one request and advance the predicted state
    task automatic predict_request(logic act, logic [7:0] b);
        logic [31:0] len;
        logic [31:0] r;
        step_results.delete();
        if (act) begin
            if (ph == PH_SESSION && mark_cfg == MARK_UPDATE)
                enter_download_phase();
        end else begin
            case (ph)
                PH_SESSION: begin
                    if (mark_cfg == MARK_BLANK) begin
                        if (b == CMD_SESSION) begin
                            step_results.push_back(
                                mk(KIND_SEND, CMD_SESSION + RESP_OFFSET, 0, 0, 0));
                            ph = PH_DOWNLOAD;
                            stp = 0;
                        end else begin
                            reject_to_session();
                        end
                    end
                end
                PH_DOWNLOAD: begin
                    if (stp == 0) begin
                        if (b == CMD_DOWNLOAD) begin
                            stp = 1;
                            cnt = 0;
                        end else begin
                            reject_to_session();
                        end
                    end else begin
                        if (cnt < 4)
                            entry_w = {entry_w[23:0], b};
                        else if (cnt < 8)
                            size_w = {size_w[23:0], b};
                        else
                            first_w = {first_w[23:0], b};
                        cnt++;
                        if (cnt >= 12) begin
                            step_results.push_back(
                                mk(KIND_SEND, CMD_DOWNLOAD + RESP_OFFSET, 0, 0, 0));
                            left_w = size_w;
                            wr_addr = first_w;
                            crc_acc = 32'hFFFFFFFF;
                            packed_w = 0;
                            cnt = 0;
                            for (int s = 2; s <= 5; s++)
                                step_results.push_back(mk(KIND_ERASE, 0, s[2:0], 0, 0));
                            ph = PH_TRANSFER;
                            stp = 0;
                        end
                    end
                end
                PH_TRANSFER: begin
                    if (stp == 0) begin
                        if (b == CMD_TRANSFER) begin
                            if (left_w == 0) begin
                                step_results.push_back(
                                    mk(KIND_SEND, CMD_TRANSFER + RESP_OFFSET, 0, 0, 0));
                                ph = PH_CRC;
                            end else begin
                                stp = 1;
                                cnt = 0;
                                packed_w = 0;
                            end
                        end else begin
                            reject_to_session();
                        end
                    end else begin
                        len = (left_w > 0 && left_w <= CHUNK) ? left_w : CHUNK;
                        crc_acc = crc_advance(crc_acc, b);
                        packed_w = packed_w | ({24'd0, b} << (8 * cnt[1:0]));
                        cnt++;
                        if (cnt[1:0] == 0 || cnt >= len) begin
                            step_results.push_back(mk(KIND_PROGRAM, 0, 0, wr_addr, packed_w));
                            wr_addr += 4;
                            packed_w = 0;
                        end
                        if (cnt >= len) begin
                            step_results.push_back(
                                mk(KIND_SEND, CMD_TRANSFER + RESP_OFFSET, 0, 0, 0));
                            cnt = 0;
                            stp = 0;
                            if (left_w <= CHUNK)
                                ph = PH_CRC;
                            else
                                left_w -= CHUNK;
                        end
                    end
                end
                PH_CRC: begin
                    if (stp == 0) begin
                        if (b == CMD_CRC) begin
                            stp = 1;
                            cnt = 0;
                            packed_w = 0;
                        end else begin
                            reject_to_session();
                        end
                    end else begin
                        packed_w = {packed_w[23:0], b};
                        cnt++;
                        if (cnt >= 4) begin
                            cnt = 0;
                            stp = 0;
                            if (packed_w == ~crc_acc) begin
                                step_results.push_back(
                                    mk(KIND_SEND, CMD_CRC + RESP_OFFSET, 0, 0, 0));
                                ph = PH_EXIT;
                            end else begin
                                step_results.push_back(mk(KIND_SEND, NEG_RESP, 0, 0, 0));
                            end
                            packed_w = 0;
                        end
                    end
                end
                PH_EXIT: begin
                    if (b == CMD_EXIT) begin
                        step_results.push_back(
                            mk(KIND_SEND, CMD_EXIT + RESP_OFFSET, 0, 0, 0));
                        step_results.push_back(mk(KIND_ERASE, 0, SECTOR_MARK, 0, 0));
                        step_results.push_back(mk(KIND_PROGRAM, 0, 0, mark_addr_cfg, first_w));
                        r = mark_addr_cfg + 4;
                        step_results.push_back(mk(KIND_PROGRAM, 0, 0, r, entry_w));
                        r = mark_addr_cfg + 8;
                        step_results.push_back(mk(KIND_PROGRAM, 0, 0, r, size_w));
                        step_results.push_back(mk(KIND_RESET, 0, 0, 0, 0));
                        ph = PH_DONE;
                        stp = 0;
                    end else begin
                        reject_to_session();
                    end
                end
                default: ;
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // Present one request and hold it until accepted; valid stays high
    // after acceptance so the next request follows with no gap unless random idling inserts one
    task automatic send_request(logic act, logic [7:0] b);
        while (idle_on && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        predict_request(act, b);
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_UPDATE_MARK)
            mark_cfg = val[1:0];
        else
            mark_addr_cfg = val;
        @(posedge clk);
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            outcome_t got;
            outcome_t want;
            got = '{kind, tx_byte, sector, address, data, last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (got.kind !== want.kind)
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.tx_byte !== want.tx_byte)
                    $display("%0t: tx_byte exp %h got %h", $time, want.tx_byte, got.tx_byte);
                if (got.sector !== want.sector)
                    $display("%0t: sector exp %0d got %0d", $time, want.sector, got.sector);
                if (got.address !== want.address)
                    $display("%0t: address exp %h got %h", $time, want.address, got.address);
                if (got.data !== want.data)
                    $display("%0t: data exp %h got %h", $time, want.data, got.data);
                if (got.last !== want.last)
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk) begin
        out_stall <= idle_on && ($urandom_range(99) < 6);
    end

    // Run a full download: session, header, chunks, crc, exit
    task automatic run_download(bit use_start, logic [31:0] sz, bit bad_crc);
        logic [31:0] chk;
        logic [31:0] n;
        if (use_start)
            send_request(1'b1, 8'h00);
        else
            send_request(1'b0, CMD_SESSION);
        send_request(1'b0, CMD_DOWNLOAD);
        for (int i = 0; i < 4; i++) send_request(1'b0, 8'($urandom_range(255)));
        for (int i = 3; i >= 0; i--) send_request(1'b0, sz[8*i +: 8]);
        for (int i = 0; i < 4; i++) send_request(1'b0, 8'($urandom_range(255)));
        n = sz;
        do begin
            send_request(1'b0, CMD_TRANSFER);
            for (int i = 0; i < ((n > CHUNK) ? CHUNK : n); i++)
                send_request(1'b0, 8'($urandom_range(255)));
            n = (n > CHUNK) ? n - CHUNK : 0;
        end while (n > 0);
        if (bad_crc) begin
            send_request(1'b0, CMD_CRC);
            chk = ~crc_acc ^ 32'h1;
            for (int i = 3; i >= 0; i--) send_request(1'b0, chk[8*i +: 8]);
        end
        send_request(1'b0, CMD_CRC);
        chk = ~crc_acc;
        for (int i = 3; i >= 0; i--) send_request(1'b0, chk[8*i +: 8]);
        send_request(1'b0, CMD_EXIT);
        n_sessions++;
    endtask

    initial begin
        row_t rows[$];
        int   k;
        errors = 0; cycles = 0; n_results = 0; n_sessions = 0; idle_on = 1'b0;
        rst_n = 1'b0; in_valid = 1'b0; action = 1'b0; rx_byte = 8'h00;
        out_stall = 1'b0; cfg_we = 1'b0; cfg_index = REG_UPDATE_MARK; cfg_data = 0;
        mark_cfg = 0; mark_addr_cfg = 0; ph = PH_SESSION; stp = 0; cnt = 0;
        entry_w = 0; size_w = 0; first_w = 0; left_w = 0; wr_addr = 0;
        packed_w = 0; crc_acc = 32'hFFFFFFFF;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; n_known < 0 means predictor only
        rows = '{
            '{1'b1, 8'hFF, 0, 8'h00},        // start event with blank mark
            '{1'b0, 8'h00, 1, NEG_RESP},     // wrong session byte
            '{1'b0, 8'hFF, 1, NEG_RESP},
            '{1'b0, CMD_SESSION, 1, 8'h20},
            '{1'b0, 8'h35, 1, NEG_RESP},     // wrong download command
            '{1'b0, CMD_SESSION, 1, 8'h20},
            '{1'b0, CMD_DOWNLOAD, 0, 8'h00},
            '{1'b0, 8'h00, 0, 8'h00}, '{1'b0, 8'h00, 0, 8'h00},
            '{1'b0, 8'h00, 0, 8'h00}, '{1'b0, 8'h00, 0, 8'h00},
            '{1'b0, 8'h00, 0, 8'h00}, '{1'b0, 8'h00, 0, 8'h00},
            '{1'b0, 8'h00, 0, 8'h00}, '{1'b0, 8'h05, 0, 8'h00},  // size 5
            '{1'b0, 8'hFF, 0, 8'h00}, '{1'b0, 8'hFF, 0, 8'h00},
            '{1'b0, 8'hFF, 0, 8'h00}, '{1'b0, 8'hFC, 5, 8'h44},
            '{1'b0, CMD_TRANSFER, 0, 8'h00},
            '{1'b0, 8'hFF, -1, 8'h00}, '{1'b0, 8'h00, -1, 8'h00},
            '{1'b0, 8'hA5, -1, 8'h00}, '{1'b0, 8'h5A, -1, 8'h00},
            '{1'b0, 8'h80, -1, 8'h00}   // partial last word
        };
        foreach (rows[i]) begin
            send_request(rows[i].action, rows[i].rx_byte);
            if (rows[i].n_known >= 0) begin
                if (step_results.size() != rows[i].n_known ||
                    (rows[i].n_known > 0 && step_results[0].tx_byte !== rows[i].first_tx)) begin
                    $display("%0t: row %0d exp %0d results first %h, predictor %0d",
                             $time, i, rows[i].n_known, rows[i].first_tx, step_results.size());
                    errors++;
                end
            end
        end
        // Wrong crc then the right one, then a wrong exit byte with a mark address at the top
        drain();
        write_reg(REG_MARK_ADDRESS, 32'hFFFFFFFF);
        send_request(1'b0, CMD_CRC);
        for (int i = 0; i < 4; i++) send_request(1'b0, 8'h00);
        send_request(1'b0, CMD_CRC);
        for (int i = 3; i >= 0; i--) send_request(1'b0, 8'((~crc_acc) >> (8 * i)));
        send_request(1'b0, 8'h00);           // wrong exit byte
        drain();

        // Update requested: start event and return to session re-entry
        write_reg(REG_UPDATE_MARK, 32'(MARK_UPDATE));
        send_request(1'b0, 8'h10);           // ignored in session with mark set
        send_request(1'b1, 8'h00);
        send_request(1'b0, 8'h00);           // fail and re-enter at once
        send_request(1'b0, CMD_DOWNLOAD);
        for (int i = 0; i < 12; i++) send_request(1'b0, 8'h00);   // zero size
        send_request(1'b0, CMD_TRANSFER);
        send_request(1'b0, CMD_CRC);
        for (int i = 0; i < 4; i++) send_request(1'b0, 8'h00);
        send_request(1'b0, CMD_EXIT);
        send_request(1'b0, CMD_SESSION);     // ignored once done
        send_request(1'b1, 8'h00);
        n_sessions++;
        drain();

        // Random requests, first with idling; reset is not repeated, so the engine
        // stays in done from the last download and only noise follows it
        idle_on = 1'b1;
        write_reg(REG_UPDATE_MARK, 32'd3);
        for (int i = 0; i < 20; i++) begin
            k = $urandom_range(1);
            send_request(k[0], 8'($urandom_range(255)));
        end
        drain();
        write_reg(REG_UPDATE_MARK, 32'd2);
        write_reg(REG_MARK_ADDRESS, 32'h0);
        send_request(1'b1, 8'h00);
        drain();
        idle_on = 1'b0;
        for (int i = 0; i < 20; i++) begin
            k = $urandom_range(1);
            send_request(k[0], 8'($urandom_range(255)));
        end
        drain();
        $display("covered %0d download sessions, %0d results checked, all phases",
                 n_sessions, n_results);
        $display("and both register extremes, with random idling on both sides");
        if (errors == 0)
            $display("PASS flash_download_protocol_engine");
        else
            $display("FAIL flash_download_protocol_engine");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/fdpe_pkg.sv
sv/fdpe_core.sv
sv/flash_download_protocol_engine.sv
dv/tb_flash_download_protocol_engine.sv
